>>> sv/hbfrl_pkg.sv
package hbfrl_pkg;

   // Field widths of the streams and registers
   localparam int BH_W      = 10;
   localparam int RATE_W    = 16;
   localparam int FIELD_W   = 16;
   localparam int CSR_A_W   = 1;
   localparam int CSR_D_W   = 16;
   localparam int REQ_D_W   = 72;

   // One second in microseconds
   localparam int US_PER_S  = 1000000;

   // Reset values of the configuration registers
   localparam logic [BH_W-1:0]   BH_RESET   = 10'd10;
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd5120;

   // Configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_SHOT_HEAT = 1'd0;
   localparam logic [CSR_A_W-1:0] CSR_RATE_CAP  = 1'd1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TIMER,
      ST_WRAP,
      ST_MUL_BUD,
      ST_MUL_COOL,
      ST_SUM,
      ST_MUL_DEN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   // Command and status between the sequencer and the divider
   typedef struct packed {
      logic start;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> sv/hbfrl_divider.sv
module hbfrl_divider #(
   parameter int DVD_W = 47,
   parameter int DSR_W = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hbfrl_pkg::div_cmd_type            cmd,
   input  logic [DVD_W-1:0]                  dividend,
   input  logic [DSR_W-1:0]                  divisor,
   input  logic [hbfrl_pkg::RATE_W-1:0]      rate_cap,
   output hbfrl_pkg::div_stat_type           stat,
   output logic [hbfrl_pkg::RATE_W-1:0]      quotient
);

   localparam int Q_W   = hbfrl_pkg::RATE_W;
   localparam int W     = (DVD_W > DSR_W + Q_W) ? DVD_W : DSR_W + Q_W;
   localparam int CNT_W = $clog2(Q_W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sat_ff, sat_in;
   logic             ge;

   // One shared compare and subtract per cycle
   assign ge = (rem_ff >= dsr_ff);

   // Restoring division, one quotient bit a cycle. The first step checks
   // whether the quotient would exceed the result width.
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = W'(dividend);
         dsr_in  = W'(divisor) << Q_W;
         q_in    = '0;
         cnt_in  = CNT_W'(Q_W);
         busy_in = 1'b1;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(Q_W)) begin
            if (ge) begin
               sat_in  = 1'b1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               dsr_in = dsr_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end else begin
            if (ge) begin
               rem_in = rem_ff - dsr_ff;
            end
            q_in   = {q_ff[Q_W-2:0], ge};
            dsr_in = dsr_ff >> 1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Clamp to the configured maximum
   assign quotient  = (sat_ff || (q_ff > rate_cap)) ? rate_cap : q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> sv/heat_budget_fire_rate_limiter.sv
// Fire rate limiter driven by barrel heat telemetry. Each request transaction is one tick
// and gives exactly one response transaction carrying the allowed rate in shots per second
// (RATE_FRAC_BITS fraction bits). Telemetry is latched whenever the tick flags it as new.
// While firing, a period timer accumulates elapsed time and the rate is recomputed only
// when it crosses SETTLE_US; otherwise the held rate is returned, and a tick without firing
// clears the limiter and returns zero. Zero is also returned when the telemetry gives no
// rate or the heat budget is used up, and the rate is clamped to the cap when the quotient
// overflows the rate width. A full recompute runs three products through one shared
// multiplier and then a 17-step serial restoring divider, one quotient bit a cycle. A
// finished tick waits while the previous response still waits in the output register.
// The block takes no new tick until the current one has moved its result into the output
// register.
module heat_budget_fire_rate_limiter #(
   parameter int SETTLE_US      = 100000,
   parameter int RESERVE_SHOTS  = 3,
   parameter int RATE_FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // firing, elapsed_us, msg_heat, msg_limit, msg_cooling, msg_valid (from bit 0 up)
   input  logic [hbfrl_pkg::REQ_D_W-1:0]      req_tdata,
   // msg_new
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // shoot_rate_q8
   output logic [hbfrl_pkg::RATE_W-1:0]       rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [hbfrl_pkg::CSR_A_W-1:0]      csr_addr,
   input  logic [hbfrl_pkg::CSR_D_W-1:0]      csr_wdata
);

   localparam int F_W    = hbfrl_pkg::FIELD_W;
   localparam int BH_W   = hbfrl_pkg::BH_W;
   localparam int R_W    = hbfrl_pkg::RATE_W;
   localparam int TMR_W  = $clog2(2 * SETTLE_US);
   localparam int EL_W   = (TMR_W > F_W) ? TMR_W : F_W;
   localparam int RES_W  = $clog2(RESERVE_SHOTS * (2**BH_W - 1) + 2);
   localparam int BUD_W  = ((RES_W > F_W) ? RES_W : F_W) + 2;
   localparam int MULB_V = (SETTLE_US > hbfrl_pkg::US_PER_S) ? SETTLE_US : hbfrl_pkg::US_PER_S;
   localparam int MULB_W = $clog2(MULB_V + 1);
   localparam int PROD_W = BUD_W + MULB_W + 1;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DEN_W  = BH_W + MULB_W;
   localparam int DVD_W  = NUM_W - 1 + RATE_FRAC_BITS;

   // Configuration registers
   logic [BH_W-1:0]  shot_heat_ff;
   logic [R_W-1:0]   rate_cap_ff;

   // Tick fields and latched telemetry
   logic             firing_ff;
   logic [F_W-1:0]   elapsed_ff;
   logic [F_W-1:0]   lat_heat_ff, lat_limit_ff, lat_cool_ff;
   logic             lat_valid_ff;

   // Limiter state
   hbfrl_pkg::state_type state_ff, state_in;
   logic [TMR_W-1:0] timer_ff, timer_in;
   logic             armed_ff, armed_in;
   logic [R_W-1:0]   held_ff, held_in;
   logic [R_W-1:0]   result_ff, result_in;

   // Datapath registers
   logic signed [BUD_W-1:0]  budget_ff, budget_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [R_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                     req_fire;
   logic                     out_free;
   logic [TMR_W-1:0]         elapsed_cap;
   logic [TMR_W-1:0]         timer_base;
   logic [TMR_W-1:0]         timer_wrap;
   logic [RES_W-1:0]         reserve_heat;
   logic                     bad_data;
   logic                     num_pos;
   logic signed [BUD_W-1:0]  mul_a;
   logic signed [MULB_W:0]   mul_b;
   logic signed [PROD_W-1:0] mul_p;
   hbfrl_pkg::div_cmd_type   div_cmd;
   hbfrl_pkg::div_stat_type  div_stat;
   logic [R_W-1:0]           div_q;

   assign req_tready = (state_ff == hbfrl_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         shot_heat_ff <= hbfrl_pkg::BH_RESET;
         rate_cap_ff  <= hbfrl_pkg::RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            hbfrl_pkg::CSR_SHOT_HEAT: shot_heat_ff <= csr_wdata[BH_W-1:0];
            hbfrl_pkg::CSR_RATE_CAP:  rate_cap_ff  <= csr_wdata[R_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the tick and latch fresh telemetry
   always_ff @(posedge clock) begin
      if (req_fire) begin
         firing_ff  <= req_tdata[0];
         elapsed_ff <= req_tdata[F_W:1];
      end
      if (reset) begin
         lat_heat_ff  <= '0;
         lat_limit_ff <= '0;
         lat_cool_ff  <= '0;
         lat_valid_ff <= 1'b0;
      end else if (req_fire && req_tuser) begin
         lat_heat_ff  <= req_tdata[2*F_W:F_W+1];
         lat_limit_ff <= req_tdata[3*F_W:2*F_W+1];
         lat_cool_ff  <= req_tdata[4*F_W:3*F_W+1];
         lat_valid_ff <= req_tdata[4*F_W+1];
      end
   end

   // Timer arithmetic
   assign elapsed_cap = (EL_W'(elapsed_ff) > EL_W'(SETTLE_US - 1)) ?
                        TMR_W'(SETTLE_US - 1) : TMR_W'(elapsed_ff);
   assign timer_base  = armed_ff ? timer_ff : TMR_W'(SETTLE_US);
   always_comb begin
      timer_wrap = timer_ff - TMR_W'(SETTLE_US);
      if (timer_wrap >= TMR_W'(SETTLE_US)) begin
         timer_wrap = timer_wrap - TMR_W'(SETTLE_US);
      end
   end

   // Heat budget and the cases that give no rate
   assign reserve_heat = RES_W'(shot_heat_ff * RESERVE_SHOTS);
   assign bad_data     = !lat_valid_ff || (lat_limit_ff == '0) || (shot_heat_ff == '0) ||
                         (lat_heat_ff >= lat_limit_ff);
   assign num_pos      = !num_ff[NUM_W-1] && (num_ff != '0);

   // Shared multiplier
   always_comb begin
      case (state_ff)
         hbfrl_pkg::ST_MUL_BUD: begin
            mul_a = budget_ff;
            mul_b = (MULB_W+1)'(hbfrl_pkg::US_PER_S);
         end
         hbfrl_pkg::ST_MUL_COOL: begin
            mul_a = BUD_W'(signed'({1'b0, lat_cool_ff}));
            mul_b = (MULB_W+1)'(SETTLE_US);
         end
         default: begin
            mul_a = BUD_W'(signed'({1'b0, shot_heat_ff}));
            mul_b = (MULB_W+1)'(SETTLE_US);
         end
      endcase
   end
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      timer_in     = timer_ff;
      armed_in     = armed_ff;
      held_in      = held_ff;
      result_in    = result_ff;
      budget_in    = budget_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      div_cmd.start = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         hbfrl_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = hbfrl_pkg::ST_TIMER;
            end
         end
         hbfrl_pkg::ST_TIMER: begin
            if (!firing_ff) begin
               held_in   = '0;
               timer_in  = '0;
               armed_in  = 1'b0;
               result_in = '0;
               state_in  = hbfrl_pkg::ST_DONE;
            end else begin
               armed_in = 1'b1;
               timer_in = timer_base + elapsed_cap;
               state_in = hbfrl_pkg::ST_WRAP;
            end
         end
         hbfrl_pkg::ST_WRAP: begin
            budget_in = BUD_W'(lat_limit_ff) - BUD_W'(reserve_heat) - BUD_W'(lat_heat_ff);
            if (timer_ff < TMR_W'(SETTLE_US)) begin
               result_in = held_ff;
               state_in  = hbfrl_pkg::ST_DONE;
            end else begin
               timer_in = timer_wrap;
               if (bad_data) begin
                  held_in   = '0;
                  result_in = '0;
                  state_in  = hbfrl_pkg::ST_DONE;
               end else begin
                  state_in = hbfrl_pkg::ST_MUL_BUD;
               end
            end
         end
         hbfrl_pkg::ST_MUL_BUD: begin
            prod_in  = mul_p;
            state_in = hbfrl_pkg::ST_MUL_COOL;
         end
         hbfrl_pkg::ST_MUL_COOL: begin
            num_in   = NUM_W'(prod_ff);
            prod_in  = mul_p;
            state_in = hbfrl_pkg::ST_SUM;
         end
         hbfrl_pkg::ST_SUM: begin
            num_in   = num_ff + NUM_W'(prod_ff);
            state_in = hbfrl_pkg::ST_MUL_DEN;
         end
         hbfrl_pkg::ST_MUL_DEN: begin
            prod_in = mul_p;
            if (!num_pos) begin
               held_in   = '0;
               result_in = '0;
               state_in  = hbfrl_pkg::ST_DONE;
            end else begin
               state_in = hbfrl_pkg::ST_DIV_START;
            end
         end
         hbfrl_pkg::ST_DIV_START: begin
            div_cmd.start = 1'b1;
            state_in      = hbfrl_pkg::ST_DIV_WAIT;
         end
         hbfrl_pkg::ST_DIV_WAIT: begin
            if (div_stat.done && !div_stat.busy) begin
               held_in   = div_q;
               result_in = div_q;
               state_in  = hbfrl_pkg::ST_DONE;
            end
         end
         hbfrl_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = hbfrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hbfrl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      budget_ff   <= budget_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= hbfrl_pkg::ST_IDLE;
         timer_ff     <= '0;
         armed_ff     <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timer_ff     <= timer_in;
         armed_ff     <= armed_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Serial divider: (num << frac) / (shot_heat * SETTLE_US), clamped
   hbfrl_divider #(
      .DVD_W (DVD_W),
      .DSR_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend ({num_ff[NUM_W-2:0], {RATE_FRAC_BITS{1'b0}}}),
      .divisor  (prod_ff[DEN_W-1:0]),
      .rate_cap (rate_cap_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
